// ----- sv/vfpi_pkg.sv -----
// Package: widths, codes, state, command and status types for the velocity-form PI controller.
`default_nettype none
package vfpi_pkg;

    localparam int DATA_W   = 16;
    localparam int GAIN_W   = 24;
    localparam int LIMIT_W  = 15;
    localparam int KI_FRAC  = 24;
    localparam int KP_FRAC  = 16;
    localparam int CFG_IDX_W = 2;

    localparam int ERR_W    = DATA_W + 1;
    localparam int DS_W     = DATA_W + 2;
    localparam int INNER_W  = DATA_W + 3;
    localparam int PROD_W   = GAIN_W + INNER_W;
    localparam int PTERM_W  = PROD_W - KP_FRAC;
    localparam int RAW_W    = PTERM_W + 1;

    localparam logic [GAIN_W-1:0]  KP_RST    = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0]  KI_T_RST  = '0;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(32767);

    localparam logic [CFG_IDX_W-1:0] CFG_KP    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KI_T  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_I,
        ST_MUL_P,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_i;
        logic mul_p;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

// ----- sv/vfpi_in_if.sv -----
// Interface: input channel carrying setpoint and measurement.
`default_nettype none
interface vfpi_in_if
    import vfpi_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measurement;

    modport source (output valid, output setpoint, output measurement, input ready);
    modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface
`default_nettype wire

// ----- sv/vfpi_out_if.sv -----
// Interface: output channel carrying drive and clamped flag.
`default_nettype none
interface vfpi_out_if
    import vfpi_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;
    logic                     clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink   (input valid, input drive, input clamped, output ready);
endinterface
`default_nettype wire

// ----- sv/vfpi_ctrl.sv -----
// Controller: sequences load, two shared-multiplier steps and the finish step.
`default_nettype none
module vfpi_ctrl
    import vfpi_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL_I;
                end
            end
            ST_MUL_I: n_state = ST_MUL_P;
            ST_MUL_P: n_state = ST_DONE;
            ST_DONE: begin
                if (!i_status.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == ST_IDLE);
        o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mul_i  = (r_state == ST_MUL_I);
        o_cmd.mul_p  = (r_state == ST_MUL_P);
        o_cmd.finish = (r_state == ST_DONE) && !i_status.out_busy;
    end

endmodule
`default_nettype wire

// ----- sv/vfpi_datapath.sv -----
// Datapath: config registers, error terms, shared multiplier, clamp and output register.
`default_nettype none
module vfpi_datapath
    import vfpi_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [GAIN_W-1:0]        i_cfg_data,
    input  wire t_cmd                     i_cmd,
    input  wire logic signed [DATA_W-1:0] i_setpoint,
    input  wire logic signed [DATA_W-1:0] i_measurement,
    input  wire logic                     i_out_ready,
    output t_status                       o_status,
    output logic                          o_out_valid,
    output logic signed [DATA_W-1:0]      o_drive,
    output logic                          o_clamped
);

    localparam logic signed [RAW_W-1:0] MAX_POS = RAW_W'((64'd1 << (DATA_W - 1)) - 64'd1);

    logic [GAIN_W-1:0]         r_kp;
    logic [GAIN_W-1:0]         r_ki_t;
    logic [LIMIT_W-1:0]        r_limit;
    logic signed [DATA_W-1:0]  r_prev_drive;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [DS_W-1:0]    r_diff;
    logic signed [DS_W-1:0]    r_sum;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_drive;
    logic                      r_clamped;

    logic signed [ERR_W-1:0]         err;
    logic signed [DS_W-1:0]          iterm;
    logic signed [INNER_W-1:0]       inner;
    logic [GAIN_W-1:0]               mul_a;
    logic signed [INNER_W-1:0]       mul_b;
    logic signed [GAIN_W+INNER_W:0]  prod_full;
    logic signed [PTERM_W-1:0]       pterm;
    logic signed [RAW_W-1:0]         raw;
    logic signed [RAW_W-1:0]         lim;
    logic signed [RAW_W-1:0]         sat;
    logic                            clip;

    always_comb begin
        err   = $signed({i_setpoint[DATA_W-1], i_setpoint})
              - $signed({i_measurement[DATA_W-1], i_measurement});
        iterm = r_prod[KI_FRAC+DS_W-1:KI_FRAC];
        inner = $signed({r_diff[DS_W-1], r_diff}) + $signed({iterm[DS_W-1], iterm});
        mul_a = i_cmd.mul_i ? r_ki_t : r_kp;
        mul_b = i_cmd.mul_i ? $signed({r_sum[DS_W-1], r_sum}) : inner;
        prod_full = $signed({1'b0, mul_a}) * mul_b;
        pterm = r_prod[PROD_W-1:KP_FRAC];
        raw   = $signed({{(RAW_W-DATA_W){r_prev_drive[DATA_W-1]}}, r_prev_drive})
              + $signed({pterm[PTERM_W-1], pterm});
        lim   = $signed({{(RAW_W-LIMIT_W){1'b0}}, r_limit});
        if (lim > MAX_POS) begin
            lim = MAX_POS;
        end
        sat  = raw;
        clip = 1'b0;
        if (raw > lim) begin
            sat  = lim;
            clip = 1'b1;
        end else if (raw < -lim) begin
            sat  = -lim;
            clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= KP_RST;
            r_ki_t  <= KI_T_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP:    r_kp    <= i_cfg_data;
                CFG_KI_T:  r_ki_t  <= i_cfg_data;
                CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_drive <= '0;
            r_prev_err   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_prev_err <= err;
            end
            if (i_cmd.finish) begin
                r_prev_drive <= sat[DATA_W-1:0];
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_diff <= $signed({err[ERR_W-1], err}) - $signed({r_prev_err[ERR_W-1], r_prev_err});
            r_sum  <= $signed({err[ERR_W-1], err}) + $signed({r_prev_err[ERR_W-1], r_prev_err});
        end
        if (i_cmd.mul_i || i_cmd.mul_p) begin
            r_prod <= prod_full[PROD_W-1:0];
        end
        if (i_cmd.finish) begin
            r_drive   <= sat[DATA_W-1:0];
            r_clamped <= clip;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_drive           = r_drive;
    assign o_clamped         = r_clamped;

endmodule
`default_nettype wire

// ----- sv/velocity_form_pi_controller_unit.sv -----
// Top level: incremental PI controller with trapezoidal integration.
// Each accepted input beat passes through the integral multiply, the proportional multiply and the
// finish step, which clamps and registers the output beat; the single shared 25x19 multiplier serves
// both products, so a new beat is taken only after the previous one has finished.
// Reset (synchronous, active low): gains and limit to defaults, stored drive and error to zero.
`default_nettype none
module velocity_form_pi_controller_unit
    import vfpi_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [GAIN_W-1:0]    i_cfg_data,
    vfpi_in_if.sink                   i_in,
    vfpi_out_if.source                o_out
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    vfpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    vfpi_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .i_setpoint    (i_in.setpoint),
        .i_measurement (i_in.measurement),
        .i_out_ready   (o_out.ready),
        .o_status      (w_status),
        .o_out_valid   (o_out.valid),
        .o_drive       (o_out.drive),
        .o_clamped     (o_out.clamped)
    );

    assign i_in.ready = w_in_ready;

`ifndef SYNTHESIS
    a_rise_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.finish))
        else $error("output valid rose without a finish step");

    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (w_cmd.mul_i && !i_in.ready))
        else $error("accepted beat did not start the integral multiply");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.mul_i, w_cmd.mul_p, w_cmd.finish}))
        else $error("more than one datapath command active");
`endif

endmodule
`default_nettype wire

// ----- bench/pi_drive_checker.sv -----
// Checker: predicts each drive beat of the PI controller and compares it with the output channel.
`timescale 1ns / 100ps
module pi_drive_checker
    import vfpi_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [GAIN_W-1:0]    i_cfg_data,
    vfpi_in_if                        i_in_mon,
    vfpi_out_if                       i_out_mon,
    output int                        o_mismatches,
    output int                        o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     clamped;
    } t_drive_beat;

    logic [GAIN_W-1:0]        kp_gain;
    logic [GAIN_W-1:0]        ki_t_gain;
    logic [LIMIT_W-1:0]       drive_limit;
    logic signed [DATA_W-1:0] last_drive;
    logic signed [ERR_W-1:0]  last_error;
    t_drive_beat              drive_q[$];

    function automatic t_drive_beat next_drive(input logic signed [DATA_W-1:0] sp,
                                               input logic signed [DATA_W-1:0] ms);
        t_drive_beat beat;
        longint err;
        longint iterm;
        longint pterm;
        longint raw;
        longint lim;
        err   = longint'(sp) - longint'(ms);
        iterm = (longint'(ki_t_gain) * (err + longint'(last_error))) >>> KI_FRAC;
        pterm = (longint'(kp_gain) * (err - longint'(last_error) + iterm)) >>> KP_FRAC;
        raw   = longint'(last_drive) + pterm;
        lim   = longint'(drive_limit);
        beat.clamped = 1'b0;
        if (raw > lim) begin
            raw = lim;
            beat.clamped = 1'b1;
        end else if (raw < -lim) begin
            raw = -lim;
            beat.clamped = 1'b1;
        end
        beat.drive = DATA_W'(raw);
        return beat;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_drive_beat want;
        if (!i_rst_n) begin
            kp_gain      = KP_RST;
            ki_t_gain    = KI_T_RST;
            drive_limit  = LIMIT_RST;
            last_drive   = '0;
            last_error   = '0;
            o_mismatches = 0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KP:    kp_gain     = i_cfg_data;
                    CFG_KI_T:  ki_t_gain   = i_cfg_data;
                    CFG_LIMIT: drive_limit = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                want = next_drive(i_in_mon.setpoint, i_in_mon.measurement);
                drive_q.push_back(want);
                last_drive = want.drive;
                last_error = ERR_W'(longint'(i_in_mon.setpoint) - longint'(i_in_mon.measurement));
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (drive_q.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected beat: drive %0d clamped %0b", $time,
                             i_out_mon.drive, i_out_mon.clamped);
                end else begin
                    want = drive_q.pop_front();
                    if (i_out_mon.drive !== want.drive) begin
                        o_mismatches++;
                        $display("%0t: drive mismatch: expected %0d, got %0d", $time,
                                 want.drive, i_out_mon.drive);
                    end
                    if (i_out_mon.clamped !== want.clamped) begin
                        o_mismatches++;
                        $display("%0t: clamped mismatch: expected %0b, got %0b", $time,
                                 want.clamped, i_out_mon.clamped);
                    end
                end
            end
        end
        o_pending = drive_q.size();
    end

endmodule

// ----- bench/tb_velocity_form_pi_controller_unit.sv -----
// Testbench top: drives setpoint/measurement beats and gain writes, reports the verdict.
`timescale 1ns / 100ps
module tb_velocity_form_pi_controller_unit;
    import vfpi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_BLOCKS  = 16;
    localparam int BLOCK_ITEMS  = 125;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [GAIN_W-1:0]    i_cfg_data;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   cycle_count = 0;
    int                   mismatches;
    int                   pending;

    vfpi_in_if  in_bus ();
    vfpi_out_if out_bus ();

    velocity_form_pi_controller_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    pi_drive_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_velocity_form_pi_controller_unit: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 53; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default:       begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
    endtask

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_sample(input logic signed [DATA_W-1:0] sp,
                               input logic signed [DATA_W-1:0] ms);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.setpoint    <= sp;
        in_bus.measurement <= ms;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain;
        in_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // the last write goes to an unmapped index and must be ignored
    task automatic load_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] lim_word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_KP;
        i_cfg_data <= kp;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_KI_T;
        i_cfg_data <= ki;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_LIMIT;
        i_cfg_data <= lim_word;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= GAIN_W'($urandom);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [GAIN_W-1:0]        kp;
        logic [GAIN_W-1:0]        ki;
        logic [GAIN_W-1:0]        lim_word;
        logic signed [DATA_W-1:0] sp;
        logic signed [DATA_W-1:0] ms;
        int                       m;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_KP;
        i_cfg_data         = '0;
        in_bus.valid       = 1'b0;
        in_bus.setpoint    = '0;
        in_bus.measurement = '0;
        out_bus.ready      = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset gains: unity kp, no integral term, full limit
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd1);
        send_sample(-16'sd1, -16'sd1);
        drain();

        // zero limit: drive pinned at zero
        load_gains('1, '1, '0);
        send_sample(16'sd100, 16'sd0);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        drain();

        // zero gains: drive holds
        load_gains('0, '0, 24'h007FFF);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd1234, 16'sd4321);
        drain();

        // small limit, upper data bits dropped by the limit register
        load_gains(24'h00C000, 24'h080000, 24'hFF8000 | 24'd1000);
        send_sample(16'sd500, 16'sd0);
        send_sample(16'sd500, 16'sd100);
        send_sample(-16'sd3000, 16'sd0);
        send_sample(16'sd0, -16'sd1);
        drain();

        // full-scale gains with full limit
        load_gains('1, '1, 24'h007FFF);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        drain();

        sp = '0;
        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            set_idle(t_idle_mode'(blk % 4));
            case ($urandom_range(3))
                0: kp = GAIN_W'($urandom);
                1: kp = GAIN_W'($urandom_range(1 << 17));
                2: kp = '0;
                default: kp = '1;
            endcase
            case ($urandom_range(3))
                0: ki = GAIN_W'($urandom);
                1: ki = GAIN_W'($urandom_range(1 << 20));
                2: ki = '0;
                default: ki = '1;
            endcase
            case ($urandom_range(3))
                0: lim_word = GAIN_W'($urandom);
                1: lim_word = {(GAIN_W-LIMIT_W)'($urandom), LIMIT_W'($urandom_range(2000))};
                2: lim_word = '0;
                default: lim_word = 24'h007FFF;
            endcase
            load_gains(kp, ki, lim_word);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                case ($urandom_range(19))
                    0: begin
                        sp = DATA_W'($urandom);
                        ms = DATA_W'($urandom);
                    end
                    1, 2: begin
                        sp = DATA_W'($urandom);
                        ms = sp;
                    end
                    3: begin
                        case ($urandom_range(3))
                            0: sp = 16'sd32767;
                            1: sp = -16'sd32768;
                            2: sp = 16'sd0;
                            default: sp = -16'sd1;
                        endcase
                        ms = $urandom_range(1) ? -sp : ~sp;
                    end
                    default: begin
                        m = int'(sp) + int'($urandom_range(1024)) - 512;
                        if (m > 32767) m = 32767;
                        if (m < -32768) m = -32768;
                        ms = DATA_W'(m);
                    end
                endcase
                send_sample(sp, ms);
            end
            drain();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("tb_velocity_form_pi_controller_unit: PASS");
        end else begin
            $display("tb_velocity_form_pi_controller_unit: FAIL");
        end
        $finish;
    end

endmodule
